// ----- hw/rtl/bcd_pkg.sv -----
// shared constants, widths and control types for the band centroid deviation block
// no dependencies; imported by bcd_div and band_centroid_deviation
`timescale 1ns / 1ps
`default_nettype none

package bcd_pkg;

  // frame and field sizes
  localparam int MAX_BINS  = 1024;
  localparam int MAG_BITS  = 16;
  localparam int PEAK_W    = 16;
  localparam int BINW_W    = 20;
  localparam int DEV_W     = 16;
  localparam int IDX_W     = $clog2(MAX_BINS + 1);
  localparam int SUM0_W    = 26;
  localparam int SUM1_W    = 36;
  localparam int FRAC_BITS = 14;

  // centroid terms: a = peak * sum0 * 256, b = sum1 * bin_width
  localparam int A_W = PEAK_W + SUM0_W + 8;
  localparam int B_W = SUM1_W + BINW_W;

  // shared multiplier operands
  localparam int MUL_A_W  = SUM0_W;
  localparam int MUL_B_W  = BINW_W;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int HALF_W   = SUM1_W / 2;
  localparam int HPROD_W  = HALF_W + BINW_W;

  // shared divider
  localparam int DIV_N_W = B_W + FRAC_BITS;
  localparam int DIV_D_W = A_W;
  localparam int DIV_Q_W = DEV_W;
  localparam int STEP_W  = $clog2(DIV_N_W + 1);

  // band edges: floor(tenths_q8 * peak / (10 * bin_width))
  localparam int LOW_TENTHS_Q8  = 2304;
  localparam int HIGH_TENTHS_Q8 = 4864;
  localparam int BAND_NUM_W     = 29;
  localparam int DEN_W          = BINW_W + 4;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = BINW_W;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BINW = CFG_IDX_W'(1);

  // reset values
  localparam int PEAK_RST = 100;
  localparam int BINW_RST = 22049;
  localparam int BAND_LOW_RAW  = (LOW_TENTHS_Q8 * PEAK_RST) / (10 * BINW_RST);
  localparam int BAND_HIGH_RAW = (HIGH_TENTHS_Q8 * PEAK_RST) / (10 * BINW_RST);
  localparam int BAND_LOW_RST  = (BAND_LOW_RAW > MAX_BINS) ? MAX_BINS : BAND_LOW_RAW;
  localparam int BAND_HIGH_RST = (BAND_HIGH_RAW > MAX_BINS) ? MAX_BINS : BAND_HIGH_RAW;

  // special deviation values
  localparam logic [DEV_W-1:0] DEV_SAT   = '1;
  localparam logic [DEV_W-1:0] DEV_EMPTY = DEV_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bcd_div.sv -----
// restoring divider, one quotient bit per cycle, shared by band edges and deviation
// keeps the low quotient bits and a sticky flag for any higher bit; uses bcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcd_div
  import bcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire div_req_t           req,
  input  wire logic [DIV_N_W-1:0] n,
  input  wire logic [DIV_D_W-1:0] d,
  output div_stat_t               stat,
  output logic      [DIV_Q_W-1:0] q
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DIV_N_W-1:0] n_r;
  logic [DIV_D_W-1:0] d_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] rem_nxt;
  logic [DIV_Q_W-1:0] q_r;
  logic               ovf_r;
  logic [DIV_D_W:0]   rem_shift;
  logic [DIV_D_W:0]   rem_sub;
  logic               take;

  // one restoring step
  always_comb begin
    rem_shift = {rem_r, n_r[DIV_N_W-1]};
    rem_sub   = rem_shift - {1'b0, d_r};
    take      = !rem_sub[DIV_D_W];
    rem_nxt   = take ? rem_sub[DIV_D_W-1:0] : rem_shift[DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      n_r   <= n;
      d_r   <= d;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      n_r   <= {n_r[DIV_N_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[DIV_Q_W-2:0], take};
      ovf_r <= ovf_r | q_r[DIV_Q_W-1];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign q         = q_r;

endmodule

`default_nettype wire

// ----- hw/rtl/band_centroid_deviation.sv -----
// top level: band-limited spectral centroid and its relative deviation from a peak
// depends on bcd_pkg and bcd_div
//
// usage
// - in_ channel: one spectrum bin per item (in_magnitude), in_last_bin on the final
//   bin of a frame; bins are numbered from 0 inside the block. while idle a bin is
//   taken every cycle; bins in [band_low, band_high) add to the two sums
// - the final bin starts the end-of-frame sequence: three passes through the
//   shared multiplier, then the shared restoring divider at one quotient bit per
//   cycle (70 steps); out_valid rises when the result enters the output register,
//   and the divide is skipped when the peak is zero or the band is empty
// - in_stall stays high from the last bin until the result enters the output
//   register; in_stall is also high whenever cfg_valid is high
// - out_ channel: one item per frame, out_deviation (unsigned q2.14, saturating)
//   and out_band_empty; a stalled receiver only holds the next frame's result
// - cfg_ channel: index 0 peak frequency, index 1 bin_width; cfg_ready is high
//   only while idle. a write recomputes both band edges on the divider, 29 steps
//   each, with cfg_ready low and bins stalled. other indexes are ignored
// - reset (rst_n low, synchronous) loads peak 100, bin width 22049, the matching
//   band edges, and clears sums, bin counter and out_valid
`timescale 1ns / 1ps
`default_nettype none

module band_centroid_deviation
  import bcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // bin input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [MAG_BITS-1:0]   in_magnitude,
  input  wire logic                  in_last_bin,
  // result output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [DEV_W-1:0]      out_deviation,
  output logic                       out_band_empty,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_BL_START = 4'd1;
  localparam logic [3:0] ST_BL_WAIT  = 4'd2;
  localparam logic [3:0] ST_BH_START = 4'd3;
  localparam logic [3:0] ST_BH_WAIT  = 4'd4;
  localparam logic [3:0] ST_MUL_A    = 4'd5;
  localparam logic [3:0] ST_MUL_B0   = 4'd6;
  localparam logic [3:0] ST_MUL_B1   = 4'd7;
  localparam logic [3:0] ST_D_START  = 4'd8;
  localparam logic [3:0] ST_D_WAIT   = 4'd9;
  localparam logic [3:0] ST_OUT      = 4'd10;

  logic [3:0]          state_r;

  // configuration and band edges
  logic [PEAK_W-1:0]   peak_r;
  logic [BINW_W-1:0]   binw_r;
  logic [IDX_W-1:0]    band_low_r;
  logic [IDX_W-1:0]    band_high_r;

  // frame accumulation
  logic [IDX_W-1:0]    idx_r;
  logic [SUM0_W-1:0]   sum0_r;
  logic [SUM1_W-1:0]   sum1_r;

  // end-of-frame terms
  logic [A_W-1:0]      a_r;
  logic [HPROD_W-1:0]  blo_r;
  logic [B_W-1:0]      b_r;
  logic [DEV_W-1:0]    dev_r;

  // output register
  logic                out_valid_r;
  logic [DEV_W-1:0]    out_dev_r;
  logic                out_empty_r;

  logic                in_take;
  logic                cfg_take;
  logic                in_band;
  logic [SUM1_W-1:0]   wprod;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;

  logic [BINW_W-1:0]   w_eff;
  logic [DEN_W-1:0]    band_den;
  logic [BAND_NUM_W-1:0] band_num;
  logic [B_W-1:0]      a_ext;
  logic [B_W-1:0]      diff;
  logic                empty;
  logic [IDX_W-1:0]    band_q;

  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [DIV_N_W-1:0]  div_n;
  logic [DIV_D_W-1:0]  div_d;
  logic [DIV_Q_W-1:0]  div_q;

  // handshakes; a register write wins over a bin in the same cycle
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_take  = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign in_take   = in_valid && !in_stall;

  assign out_valid      = out_valid_r;
  assign out_deviation  = out_dev_r;
  assign out_band_empty = out_empty_r;

  // per-bin accumulate
  assign in_band = (idx_r >= band_low_r) && (idx_r < band_high_r);
  assign wprod   = SUM1_W'(in_magnitude) * SUM1_W'(idx_r);

  // shared multiplier: peak * sum0, then the two halves of sum1 * bin_width
  always_comb begin
    case (state_r)
      ST_MUL_A: begin
        mul_a = sum0_r;
        mul_b = MUL_B_W'(peak_r);
      end
      ST_MUL_B0: begin
        mul_a = MUL_A_W'(sum1_r[HALF_W-1:0]);
        mul_b = binw_r;
      end
      ST_MUL_B1: begin
        mul_a = MUL_A_W'(sum1_r[SUM1_W-1:HALF_W]);
        mul_b = binw_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // band edge operands; a zero bin width counts as the smallest step
  assign w_eff    = (binw_r == '0) ? BINW_W'(1) : binw_r;
  assign band_den = {1'b0, w_eff, 3'b000} + {3'b000, w_eff, 1'b0};
  assign band_num = (state_r == ST_BH_START)
                  ? BAND_NUM_W'(HIGH_TENTHS_Q8) * BAND_NUM_W'(peak_r)
                  : BAND_NUM_W'(LOW_TENTHS_Q8) * BAND_NUM_W'(peak_r);

  // deviation operands
  assign a_ext = B_W'(a_r);
  assign diff  = (a_ext > b_r) ? (a_ext - b_r) : (b_r - a_ext);
  assign empty = (sum0_r == '0);

  // divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = STEP_W'(BAND_NUM_W);
    div_n         = {band_num, (DIV_N_W - BAND_NUM_W)'(0)};
    div_d         = DIV_D_W'(band_den);
    case (state_r)
      ST_BL_START, ST_BH_START: begin
        div_req.start = 1'b1;
      end
      ST_D_START: begin
        div_req.start = (peak_r != '0) && !empty;
        div_req.steps = STEP_W'(DIV_N_W);
        div_n         = {diff, FRAC_BITS'(0)};
        div_d         = a_r;
      end
      default: begin
      end
    endcase
  end

  // band edges clamp at the frame limit
  assign band_q = (div_stat.ovf || ({1'b0, div_q} > (DIV_Q_W + 1)'(MAX_BINS)))
                ? IDX_W'(MAX_BINS) : IDX_W'(div_q);

  bcd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .n     (div_n),
    .d     (div_d),
    .stat  (div_stat),
    .q     (div_q)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      peak_r      <= PEAK_W'(PEAK_RST);
      binw_r      <= BINW_W'(BINW_RST);
      band_low_r  <= IDX_W'(BAND_LOW_RST);
      band_high_r <= IDX_W'(BAND_HIGH_RST);
      idx_r       <= '0;
      sum0_r      <= '0;
      sum1_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cfg_take) begin
            case (cfg_index)
              CFG_PEAK: begin
                peak_r  <= cfg_data[PEAK_W-1:0];
                state_r <= ST_BL_START;
              end
              CFG_BINW: begin
                binw_r  <= cfg_data[BINW_W-1:0];
                state_r <= ST_BL_START;
              end
              default: begin
              end
            endcase
          end else if (in_take) begin
            if (in_band) begin
              sum0_r <= sum0_r + SUM0_W'(in_magnitude);
              sum1_r <= sum1_r + wprod;
            end
            if (idx_r < IDX_W'(MAX_BINS)) begin
              idx_r <= idx_r + IDX_W'(1);
            end
            if (in_last_bin) begin
              state_r <= ST_MUL_A;
            end
          end
        end
        ST_BL_START: state_r <= ST_BL_WAIT;
        ST_BL_WAIT: begin
          if (div_stat.done) begin
            band_low_r <= band_q;
            state_r    <= ST_BH_START;
          end
        end
        ST_BH_START: state_r <= ST_BH_WAIT;
        ST_BH_WAIT: begin
          if (div_stat.done) begin
            band_high_r <= band_q;
            state_r     <= ST_IDLE;
          end
        end
        ST_MUL_A:  state_r <= ST_MUL_B0;
        ST_MUL_B0: state_r <= ST_MUL_B1;
        ST_MUL_B1: state_r <= ST_D_START;
        ST_D_START: begin
          // zero peak saturates, empty band reads as a ratio of one
          state_r <= (div_req.start) ? ST_D_WAIT : ST_OUT;
        end
        ST_D_WAIT: begin
          if (div_stat.done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            idx_r       <= '0;
            sum0_r      <= '0;
            sum1_r      <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // end-of-frame payload
  always_ff @(posedge clk) begin
    case (state_r)
      ST_MUL_A:  a_r   <= {mul_p[PEAK_W+SUM0_W-1:0], 8'b0};
      ST_MUL_B0: blo_r <= mul_p[HPROD_W-1:0];
      ST_MUL_B1: b_r   <= B_W'(blo_r) + {mul_p[B_W-HALF_W-1:0], HALF_W'(0)};
      ST_D_START: begin
        if (peak_r == '0) begin
          dev_r <= DEV_SAT;
        end else if (empty) begin
          dev_r <= DEV_EMPTY;
        end
      end
      ST_D_WAIT: begin
        if (div_stat.done) begin
          dev_r <= div_stat.ovf ? DEV_SAT : div_q;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_dev_r   <= dev_r;
          out_empty_r <= empty;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking testbench for band_centroid_deviation: streams spectrum frames through the
// block, predicts each frame's deviation item locally and compares it at the result port
// depends on bcd_pkg and the block's rtl
`timescale 1ns / 1ps

module testbench;
  import bcd_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int ITEM_TARGET    = 1950;
  localparam int MIN_FRAMES     = 40;
  localparam int SETTLE_CYCLES  = 90;      // end-of-frame math plus margin
  localparam int RX_HOLD_CYCLES = 500;
  localparam int CYCLE_LIMIT    = 500000;

  // band edges as tenths in q8: 9 and 19 tenths (0.9 and 1.9) times 256
  localparam int EDGE_LO_Q8     = 2304;
  localparam int EDGE_HI_Q8     = 4864;
  localparam int PEAK_AT_RESET  = 100;
  localparam int WIDTH_AT_RESET = 22049;
  localparam logic [DEV_W-1:0] DEV_FULL = '1;
  localparam logic [DEV_W-1:0] DEV_ONE  = DEV_W'(1 << 14);

  typedef struct packed {
    logic [DEV_W-1:0] deviation;
    logic             band_empty;
  } centroid_result_t;

  // dut ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [MAG_BITS-1:0]   in_magnitude = '0;
  logic                  in_last_bin = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  logic [DEV_W-1:0]      out_deviation;
  logic                  out_band_empty;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // local copy of the block's registers and frame state
  logic [15:0] peak_hz;
  logic [19:0] bin_width_q8;
  logic [10:0] band_lo;
  logic [10:0] band_hi;
  logic [10:0] bin_pos;
  logic [63:0] mag_total;
  logic [63:0] weighted_total;

  centroid_result_t pending_results[$];

  int unsigned fail_count = 0;
  int unsigned bins_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned results_checked = 0;
  int unsigned cycle_count = 0;

  // idling controls, changed per phase
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int unsigned rx_hold_requests = 0;

  // receiver-side counters, owned by the stall process
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_taken_seen = 0;
  int unsigned rx_wait = 0;

  band_centroid_deviation u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_magnitude   (in_magnitude),
    .in_last_bin    (in_last_bin),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_deviation  (out_deviation),
    .out_band_empty (out_band_empty),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------- prediction

  // floor(tenths_q8 * peak / (10 * width)), zero width taken as one step, capped at MAX_BINS
  function automatic logic [10:0] band_edge(input int unsigned tenths_q8);
    logic [63:0] w;
    logic [63:0] v;
    w = (bin_width_q8 == '0) ? 64'd1 : 64'(bin_width_q8);
    v = (64'(tenths_q8) * 64'(peak_hz)) / (64'd10 * w);
    return (v > 64'(MAX_BINS)) ? 11'(MAX_BINS) : 11'(v);
  endfunction

  function automatic void update_band();
    band_lo = band_edge(EDGE_LO_Q8);
    band_hi = band_edge(EDGE_HI_Q8);
  endfunction

  // |P*S0*256 - S1*W| / (P*S0*256) in q2.14, truncated and saturated
  function automatic logic [DEV_W-1:0] centroid_deviation();
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] diff;
    logic [127:0] q;
    if (peak_hz == '0) return DEV_FULL;
    if (mag_total == '0) return DEV_ONE;
    a = 128'(peak_hz) * 128'(mag_total) * 128'd256;
    b = 128'(weighted_total) * 128'(bin_width_q8);
    diff = (a > b) ? a - b : b - a;
    q = (diff << 14) / a;
    return (q > 128'(DEV_FULL)) ? DEV_FULL : q[DEV_W-1:0];
  endfunction

  function automatic void reset_predictor();
    peak_hz = 16'(PEAK_AT_RESET);
    bin_width_q8 = 20'(WIDTH_AT_RESET);
    mag_total = '0;
    weighted_total = '0;
    bin_pos = '0;
    update_band();
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_PEAK) begin
      peak_hz = data[15:0];
      update_band();
    end else if (idx == CFG_BINW) begin
      bin_width_q8 = data[19:0];
      update_band();
    end
  endfunction

  // one accepted bin: accumulate inside the band, emit on the final bin
  function automatic void absorb_bin(input logic [MAG_BITS-1:0] mag, input logic last);
    centroid_result_t want;
    if (bin_pos >= band_lo && bin_pos < band_hi) begin
      mag_total += 64'(mag);
      weighted_total += 64'(mag) * 64'(bin_pos);
    end
    if (bin_pos < 11'(MAX_BINS)) bin_pos++;
    if (last) begin
      want.deviation = centroid_deviation();
      want.band_empty = (mag_total == '0);
      pending_results.push_back(want);
      mag_total = '0;
      weighted_total = '0;
      bin_pos = '0;
      frames_sent++;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : result_check
    centroid_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending (deviation)", 32'd0, 32'(out_deviation));
      end else begin
        want = pending_results.pop_front();
        if (out_deviation !== want.deviation)
          note_mismatch("deviation", 32'(want.deviation), 32'(out_deviation));
        if (out_band_empty !== want.band_empty)
          note_mismatch("band_empty", 32'(want.band_empty), 32'(out_band_empty));
      end
      results_checked++;
    end
  end

  // receiver: random wait after each item while rx_idle is set, long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_seen != rx_hold_requests) begin
      rx_hold_seen = rx_hold_requests;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_taken_seen != results_checked) begin
      rx_taken_seen = results_checked;
      rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait != 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("watchdog expired after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- drivers

  // offer one bin after a random gap when tx_idle is set, hold it until taken
  task automatic send_bin(input logic [MAG_BITS-1:0] mag, input logic last);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_magnitude <= mag;
    in_last_bin <= last;
    do @(posedge clk); while (in_stall);
    absorb_bin(mag, last);
    bins_sent++;
  endtask

  // stop offering bins and wait for every pending result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // drained plus time for any end-of-frame work still in flight
  task automatic quiesce();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [MAG_BITS-1:0] pick_magnitude(input bit quiet);
    if (quiet) return '0;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return MAG_BITS'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int unsigned len, input bit quiet);
    for (int unsigned i = 0; i < len; i++)
      send_bin(pick_magnitude(quiet), i == len - 1);
  endtask

  // random peak and width, mostly steered so the band starts on one of the first bins
  task automatic pick_setting();
    logic [19:0] width;
    logic [15:0] peak;
    logic [63:0] peak_calc;
    case ($urandom_range(0, 15))
      0: width = '0;
      1: width = 20'd1;
      2: width = '1;
      3, 4: width = 20'($urandom_range(2, 4095));
      default: width = 20'($urandom);
    endcase
    peak_calc = (64'($urandom_range(0, 24)) * 64'd10 * 64'(width)) / 64'(EDGE_LO_Q8)
                + 64'($urandom_range(0, 2));
    case ($urandom_range(0, 15))
      0: peak = '0;
      1: peak = '1;
      2: peak = 16'($urandom);
      default: peak = (peak_calc > 64'hFFFF) ? 16'hFFFF :
                      (peak_calc == 0) ? 16'd1 : peak_calc[15:0];
    endcase
    // upper data bits above the peak field are don't-care
    if ($urandom_range(0, 1)) begin
      write_register(CFG_PEAK, {4'($urandom), peak});
      write_register(CFG_BINW, width);
    end else begin
      write_register(CFG_BINW, width);
      write_register(CFG_PEAK, {4'($urandom), peak});
    end
    if ($urandom_range(0, 3) == 0)
      write_register(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
  endtask

  // ---------------------------------------------------------------- tests

  // reset values: band is bin 1 only
  task automatic test_reset_defaults();
    send_bin(16'h0000, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'hFFFF, 1'b1);
  endtask

  // single-bin frame, bin 0 lies below the band
  task automatic test_empty_band();
    send_bin(16'h5555, 1'b1);
  endtask

  // peak of zero: collapsed band and saturated deviation
  task automatic test_zero_peak();
    quiesce();
    write_register(CFG_PEAK, 20'hF0000);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h8001, 1'b1);
  endtask

  // widening the bins mid-frame pushes the centroid far above the peak
  task automatic test_ratio_saturation();
    quiesce();
    write_register(CFG_PEAK, 20'd1000);
    write_register(CFG_BINW, 20'd100000);
    send_bin(16'h1234, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h8000, 1'b0);
    quiesce();
    write_register(CFG_BINW, 20'hFFFFF);
    send_bin(16'hFFFF, 1'b1);
  endtask

  // both edges clip at MAX_BINS
  task automatic test_band_clipping();
    quiesce();
    write_register(CFG_PEAK, 20'h0FFFF);
    write_register(CFG_BINW, 20'd1);
    send_bin(16'h00FF, 1'b0);
    send_bin(16'hFF00, 1'b1);
  endtask

  // writes to unused indexes must leave the band at [1, 3)
  task automatic test_unknown_register();
    quiesce();
    write_register(CFG_PEAK, 20'd200);
    write_register(CFG_BINW, 20'd30000);
    write_register(CFG_IDX_W'(15), 20'hFFFFF);
    write_register(CFG_IDX_W'(2), CFG_DATA_W'($urandom));
    send_bin(16'hA5A5, 1'b0);
    send_bin(16'h0001, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h7FFF, 1'b1);
  endtask

  // zero width: band from the one-step rule, centroid forced to 0
  task automatic test_zero_bin_width();
    quiesce();
    write_register(CFG_PEAK, 20'd1);
    write_register(CFG_BINW, 20'd0);
    send_frame(240, 1'b0);
  endtask

  // frame past MAX_BINS at full rate, band running into the top bin
  task automatic test_long_frame();
    quiesce();
    write_register(CFG_PEAK, 20'd1010);
    write_register(CFG_BINW, 20'd256);
    tx_idle = 1'b0;
    send_frame(1030, 1'b0);
    tx_idle = 1'b1;
  endtask

  // receiver holds off while frames keep coming, then the sender waits for all results
  task automatic test_backpressure();
    quiesce();
    write_register(CFG_PEAK, 20'd200);
    write_register(CFG_BINW, 20'd30000);
    rx_hold_requests++;
    tx_idle = 1'b0;
    repeat (4) send_frame(5, 1'b0);
    tx_idle = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_frames();
    int unsigned frames;
    int unsigned span;
    int unsigned len;
    while (bins_sent < ITEM_TARGET || frames_sent < MIN_FRAMES) begin
      quiesce();
      pick_setting();
      // about a quarter of the phases run without idling on a side
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      frames = $urandom_range(1, 6);
      repeat (frames) begin
        span = int'(band_hi) + 3;
        if (span > 48) span = 48;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 80) : $urandom_range(1, span);
        send_frame(len, $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d bins in %0d frames with %0d register writes", bins_sent,
             frames_sent, reg_writes);
    $display("checked %0d results in %0d cycles, %0d mismatches", results_checked,
             cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  endtask

  initial begin
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_empty_band();
    test_zero_peak();
    test_ratio_saturation();
    test_band_clipping();
    test_unknown_register();
    test_zero_bin_width();
    test_long_frame();
    test_backpressure();
    test_random_frames();
    finish_run();
  end

endmodule
